>>> design/mrr_pkg.sv
`timescale 1ns / 1ps
// mrr_pkg: shared constants, codes and types of the 3D mesh router.
// No dependencies; used by every module of the router except mrr_ram.
package mrr_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int NPORTS      = 7;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH   = NPORTS * QUEUE_DEPTH;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int ENTRY_W     = 4 + 4 + 3 + 8;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_UNSTALL = 2'd2;
    localparam logic [1:0] OP_STALL   = 2'd3;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_FWD     = 2'd1;
    localparam logic [1:0] KIND_UNSTALL = 2'd2;
    localparam logic [1:0] KIND_IDLE    = 2'd3;

    localparam logic [2:0] P_RIGHT  = 3'd0;
    localparam logic [2:0] P_LEFT   = 3'd1;
    localparam logic [2:0] P_UP     = 3'd2;
    localparam logic [2:0] P_DOWN   = 3'd3;
    localparam logic [2:0] P_LOCAL  = 3'd4;
    localparam logic [2:0] P_ZPLUS  = 3'd5;
    localparam logic [2:0] P_ZMINUS = 3'd6;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_POS_Z  = 3'd2;
    localparam logic [2:0] REG_MESH_X = 3'd3;
    localparam logic [2:0] REG_MESH_Y = 3'd4;
    localparam logic [2:0] REG_MESH_Z = 3'd5;
    localparam logic [2:0] REG_LIMIT  = 3'd6;

    typedef struct packed {
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [2:0] pos_z;
        logic [4:0] mesh_x_count;
        logic [4:0] mesh_y_count;
        logic [3:0] mesh_z_count;
        logic [2:0] queue_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] q;
        logic [3:0] dx;
        logic [3:0] dy;
        logic [2:0] dz;
        logic [7:0] id;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] port;
        logic [7:0] id;
        logic [3:0] dx;
        logic [3:0] dy;
        logic [2:0] dz;
        logic       stall;
        logic       ovf;
        logic       last;
    } t_res;

endpackage

>>> design/mesh_router_round_robin_zxy_core.sv
`timescale 1ns / 1ps
// mesh_router_round_robin_zxy_core: top level of the 3D mesh router, APB registers.
// Depends on mrr_pkg, mrr_front, mrr_back (which holds mrr_ram).
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------
//  input   | i_valid / o_ready | opcode, source_x/y/z, dest_x/y/z, req_id
//  output  | o_valid / i_ready | kind, port, out_req_id, out_dest_x/y/z,
//          |                   | source_must_stall, overflow, last
//  config  | psel/penable      | paddr, pwdata, prdata, pwrite, pready
//
// Push, stall and unstall: the result register loads from the command at the head
// of the front queue once the output side is free.
// A tick runs from dispatch through a read and a next step for every queue, an
// evaluation of every non-empty head, a hand-over per forwarded request and per
// unstall, and a final hand-over of the last result; output stalls hold it.
// Reset is synchronous; no memory clearing pass, queue entries are undefined.
// The front queue holds two transactions, so input accepts while the back end
// or the output side stalls.
module mesh_router_round_robin_zxy_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_source_x,
    input  logic [3:0]  i_source_y,
    input  logic [2:0]  i_source_z,
    input  logic [3:0]  i_dest_x,
    input  logic [3:0]  i_dest_y,
    input  logic [2:0]  i_dest_z,
    input  logic [7:0]  i_req_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_port,
    output logic [7:0]  o_out_req_id,
    output logic [3:0]  o_out_dest_x,
    output logic [3:0]  o_out_dest_y,
    output logic [2:0]  o_out_dest_z,
    output logic        o_source_must_stall,
    output logic        o_overflow,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mrr_pkg::t_cfg r_cfg;
    mrr_pkg::t_cmd cmd;
    mrr_pkg::t_res res;
    logic          cmd_valid;
    logic          cmd_pop;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x        <= 4'd0;
            r_cfg.pos_y        <= 4'd0;
            r_cfg.pos_z        <= 3'd0;
            r_cfg.mesh_x_count <= 5'd4;
            r_cfg.mesh_y_count <= 5'd4;
            r_cfg.mesh_z_count <= 4'd1;
            r_cfg.queue_limit  <= 3'd4;
        end else if (wr) begin
            unique case (paddr[4:2])
                mrr_pkg::REG_POS_X:  r_cfg.pos_x        <= pwdata[3:0];
                mrr_pkg::REG_POS_Y:  r_cfg.pos_y        <= pwdata[3:0];
                mrr_pkg::REG_POS_Z:  r_cfg.pos_z        <= pwdata[2:0];
                mrr_pkg::REG_MESH_X: r_cfg.mesh_x_count <= pwdata[4:0];
                mrr_pkg::REG_MESH_Y: r_cfg.mesh_y_count <= pwdata[4:0];
                mrr_pkg::REG_MESH_Z: r_cfg.mesh_z_count <= pwdata[3:0];
                mrr_pkg::REG_LIMIT:  r_cfg.queue_limit  <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            mrr_pkg::REG_POS_X:  prdata = 32'(r_cfg.pos_x);
            mrr_pkg::REG_POS_Y:  prdata = 32'(r_cfg.pos_y);
            mrr_pkg::REG_POS_Z:  prdata = 32'(r_cfg.pos_z);
            mrr_pkg::REG_MESH_X: prdata = 32'(r_cfg.mesh_x_count);
            mrr_pkg::REG_MESH_Y: prdata = 32'(r_cfg.mesh_y_count);
            mrr_pkg::REG_MESH_Z: prdata = 32'(r_cfg.mesh_z_count);
            mrr_pkg::REG_LIMIT:  prdata = 32'(r_cfg.queue_limit);
            default:             prdata = 32'd0;
        endcase
    end

    mrr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_source_x  (i_source_x),
        .i_source_y  (i_source_y),
        .i_source_z  (i_source_z),
        .i_dest_x    (i_dest_x),
        .i_dest_y    (i_dest_y),
        .i_dest_z    (i_dest_z),
        .i_req_id    (i_req_id),
        .i_cfg       (r_cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    assign o_kind              = res.kind;
    assign o_port              = res.port;
    assign o_out_req_id        = res.id;
    assign o_out_dest_x        = res.dx;
    assign o_out_dest_y        = res.dy;
    assign o_out_dest_z        = res.dz;
    assign o_source_must_stall = res.stall;
    assign o_overflow          = res.ovf;
    assign o_last              = res.last;

endmodule

>>> design/mrr_ram.sv
`timescale 1ns / 1ps
// mrr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mrr_front.sv
`timescale 1ns / 1ps
// mrr_front: input handshake, port classification and a two-entry command queue.
// Depends on mrr_pkg.
module mrr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_opcode,
    input  logic [3:0]    i_source_x,
    input  logic [3:0]    i_source_y,
    input  logic [2:0]    i_source_z,
    input  logic [3:0]    i_dest_x,
    input  logic [3:0]    i_dest_y,
    input  logic [2:0]    i_dest_z,
    input  logic [7:0]    i_req_id,
    input  mrr_pkg::t_cfg i_cfg,
    output logic          o_cmd_valid,
    output mrr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    mrr_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    mrr_pkg::t_cmd cls;
    logic          push;
    logic          pop;

    // Z first, then X, then Y, local when all match
    always_comb begin
        cls.op = i_opcode;
        cls.dx = i_dest_x;
        cls.dy = i_dest_y;
        cls.dz = i_dest_z;
        cls.id = i_req_id;
        if (i_source_z != i_cfg.pos_z) begin
            cls.q = (i_source_z < i_cfg.pos_z) ? mrr_pkg::P_ZMINUS : mrr_pkg::P_ZPLUS;
        end else if (i_source_x != i_cfg.pos_x) begin
            cls.q = (i_source_x < i_cfg.pos_x) ? mrr_pkg::P_LEFT : mrr_pkg::P_RIGHT;
        end else if (i_source_y != i_cfg.pos_y) begin
            cls.q = (i_source_y < i_cfg.pos_y) ? mrr_pkg::P_DOWN : mrr_pkg::P_UP;
        end else begin
            cls.q = mrr_pkg::P_LOCAL;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> design/mrr_back.sv
`timescale 1ns / 1ps
// mrr_back: queue state, round-robin arbitration sequencer and result register.
// Depends on mrr_pkg and mrr_ram.
module mrr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mrr_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  mrr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output mrr_pkg::t_res o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_PUTU = 3'd3;
    localparam logic [2:0] S_PUTF = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] LAST_IDX = 3'(mrr_pkg::NPORTS - 1);

    logic [2:0]                  r_state;
    logic [mrr_pkg::QPTR_W-1:0]  r_heads   [mrr_pkg::NPORTS];
    logic [mrr_pkg::CNT_W-1:0]   r_counts  [mrr_pkg::NPORTS];
    logic [mrr_pkg::NPORTS-1:0]  r_stalled;
    logic [mrr_pkg::NPORTS-1:0]  r_taken;
    logic [2:0]                  r_rr;
    logic [2:0]                  r_idx;
    logic [2:0]                  r_step;
    logic                        r_hv;
    mrr_pkg::t_res               r_hold;
    mrr_pkg::t_res               r_fwd;
    logic                        r_ov;
    mrr_pkg::t_res               r_out;

    logic                        out_free;
    logic [mrr_pkg::CNT_W-1:0]   cnt_q;
    logic                        full_q;
    logic [mrr_pkg::CNT_W-1:0]   cnt_new;
    logic [mrr_pkg::QPTR_W:0]    slot_sum;
    logic [mrr_pkg::QPTR_W-1:0]  slot;
    logic                        we;
    logic [mrr_pkg::MEM_AW-1:0]  waddr;
    logic [mrr_pkg::MEM_AW-1:0]  raddr;
    logic [mrr_pkg::ENTRY_W-1:0] rdata;
    logic [3:0]                  e_dx;
    logic [3:0]                  e_dy;
    logic [2:0]                  e_dz;
    logic [7:0]                  e_id;
    logic [2:0]                  rt_port;
    logic                        rt_on;
    logic [4:0]                  nx;
    logic [4:0]                  ny;
    logic [3:0]                  nz;
    logic                        uf;
    logic [mrr_pkg::CNT_W-1:0]   cnt_idx;
    logic [mrr_pkg::CNT_W-1:0]   cnt_dec;
    logic [mrr_pkg::CNT_W-1:0]   lim_ext;
    logic [2:0]                  idx_nxt;
    mrr_pkg::t_res               res_unstall;
    logic                        load;
    mrr_pkg::t_res               out_nxt;

    assign out_free = !r_ov || i_ready;
    assign lim_ext  = mrr_pkg::CNT_W'(i_cfg.queue_limit);

    // push side
    assign cnt_q    = r_counts[i_cmd.q];
    assign full_q   = (cnt_q == mrr_pkg::CNT_W'(mrr_pkg::QUEUE_DEPTH));
    assign cnt_new  = full_q ? cnt_q : cnt_q + 1'b1;
    assign slot_sum = (mrr_pkg::QPTR_W+1)'(r_heads[i_cmd.q])
                    + (mrr_pkg::QPTR_W+1)'(cnt_q);
    assign slot     = (slot_sum >= (mrr_pkg::QPTR_W+1)'(mrr_pkg::QUEUE_DEPTH))
                    ? mrr_pkg::QPTR_W'(slot_sum - (mrr_pkg::QPTR_W+1)'(mrr_pkg::QUEUE_DEPTH))
                    : mrr_pkg::QPTR_W'(slot_sum);
    assign we       = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == mrr_pkg::OP_PUSH)
                    && out_free && !full_q;
    assign waddr    = mrr_pkg::MEM_AW'(i_cmd.q) * mrr_pkg::MEM_AW'(mrr_pkg::QUEUE_DEPTH)
                    + mrr_pkg::MEM_AW'(slot);
    assign raddr    = mrr_pkg::MEM_AW'(r_idx) * mrr_pkg::MEM_AW'(mrr_pkg::QUEUE_DEPTH)
                    + mrr_pkg::MEM_AW'(r_heads[r_idx]);

    mrr_ram #(
        .WIDTH (mrr_pkg::ENTRY_W),
        .DEPTH (mrr_pkg::MEM_DEPTH)
    ) u_qram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_cmd.dx, i_cmd.dy, i_cmd.dz, i_cmd.id}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign {e_dx, e_dy, e_dz, e_id} = rdata;

    // next hop of the head entry, Z then X then Y
    always_comb begin
        nx      = {1'b0, i_cfg.pos_x};
        ny      = {1'b0, i_cfg.pos_y};
        nz      = {1'b0, i_cfg.pos_z};
        uf      = 1'b0;
        rt_port = mrr_pkg::P_LOCAL;
        rt_on   = 1'b1;
        if (!(e_dx == i_cfg.pos_x && e_dy == i_cfg.pos_y && e_dz == i_cfg.pos_z)) begin
            if (e_dz != i_cfg.pos_z) begin
                if (e_dz < i_cfg.pos_z) begin
                    rt_port = mrr_pkg::P_ZMINUS;
                    uf      = (i_cfg.pos_z == 3'd0);
                    nz      = nz - 4'd1;
                end else begin
                    rt_port = mrr_pkg::P_ZPLUS;
                    nz      = nz + 4'd1;
                end
            end else if (e_dx != i_cfg.pos_x) begin
                if (e_dx < i_cfg.pos_x) begin
                    rt_port = mrr_pkg::P_LEFT;
                    uf      = (i_cfg.pos_x == 4'd0);
                    nx      = nx - 5'd1;
                end else begin
                    rt_port = mrr_pkg::P_RIGHT;
                    nx      = nx + 5'd1;
                end
            end else begin
                if (e_dy < i_cfg.pos_y) begin
                    rt_port = mrr_pkg::P_DOWN;
                    uf      = (i_cfg.pos_y == 4'd0);
                    ny      = ny - 5'd1;
                end else begin
                    rt_port = mrr_pkg::P_UP;
                    ny      = ny + 5'd1;
                end
            end
            rt_on = !uf && (nx < i_cfg.mesh_x_count) && (ny < i_cfg.mesh_y_count)
                  && (nz < i_cfg.mesh_z_count);
        end
    end

    assign cnt_idx = r_counts[r_idx];
    assign cnt_dec = cnt_idx - 1'b1;
    assign idx_nxt = (r_idx == LAST_IDX) ? 3'd0 : r_idx + 3'd1;

    always_comb begin
        res_unstall      = '0;
        res_unstall.kind = mrr_pkg::KIND_UNSTALL;
        res_unstall.port = r_idx;
    end

    // what the result register loads this cycle, if anything
    always_comb begin
        load    = 1'b0;
        out_nxt = r_hold;
        unique case (r_state)
            S_IDLE: begin
                load         = i_cmd_valid && (i_cmd.op != mrr_pkg::OP_TICK) && out_free;
                out_nxt      = '0;
                out_nxt.port = i_cmd.q;
                out_nxt.last = 1'b1;
                if (i_cmd.op == mrr_pkg::OP_PUSH) begin
                    out_nxt.kind  = mrr_pkg::KIND_PUSH;
                    out_nxt.stall = (cnt_new > lim_ext);
                    out_nxt.ovf   = full_q;
                end else begin
                    out_nxt.kind  = mrr_pkg::KIND_IDLE;
                end
            end
            S_PUTU: begin
                load = r_hv && out_free;
            end
            S_PUTF: begin
                load = r_hv && out_free;
            end
            S_FIN: begin
                load = out_free;
                if (r_hv) begin
                    out_nxt.last = 1'b1;
                end else begin
                    out_nxt      = '0;
                    out_nxt.kind = mrr_pkg::KIND_IDLE;
                    out_nxt.last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid
                    && ((i_cmd.op == mrr_pkg::OP_TICK) || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stalled <= '0;
            r_taken   <= '0;
            r_rr      <= 3'd0;
            r_idx     <= 3'd0;
            r_step    <= 3'd0;
            r_hv      <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < mrr_pkg::NPORTS; i++) begin
                r_heads[i]  <= '0;
                r_counts[i] <= '0;
            end
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_out <= out_nxt;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == mrr_pkg::OP_TICK) begin
                            r_idx   <= r_rr;
                            r_step  <= 3'd0;
                            r_taken <= '0;
                            r_hv    <= 1'b0;
                            r_state <= S_RD;
                        end else if (out_free) begin
                            if (i_cmd.op == mrr_pkg::OP_PUSH) begin
                                r_counts[i_cmd.q] <= cnt_new;
                            end else begin
                                r_stalled[i_cmd.q] <= (i_cmd.op == mrr_pkg::OP_STALL);
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= (cnt_idx != '0) ? S_EV : S_NEXT;
                end
                S_EV: begin
                    r_state <= S_NEXT;
                    if (!r_taken[rt_port]) begin
                        r_taken[rt_port] <= 1'b1;
                        if (!r_stalled[rt_port]) begin
                            r_heads[r_idx]  <= (r_heads[r_idx] ==
                                                mrr_pkg::QPTR_W'(mrr_pkg::QUEUE_DEPTH - 1))
                                             ? '0 : r_heads[r_idx] + 1'b1;
                            r_counts[r_idx] <= cnt_dec;
                            r_rr            <= idx_nxt;
                            r_fwd.kind  <= mrr_pkg::KIND_FWD;
                            r_fwd.port  <= rt_on ? rt_port : mrr_pkg::P_LOCAL;
                            r_fwd.id    <= e_id;
                            r_fwd.dx    <= e_dx;
                            r_fwd.dy    <= e_dy;
                            r_fwd.dz    <= e_dz;
                            r_fwd.stall <= 1'b0;
                            r_fwd.ovf   <= 1'b0;
                            r_fwd.last  <= 1'b0;
                            r_state <= (cnt_dec == lim_ext) ? S_PUTU : S_PUTF;
                        end
                    end
                end
                // the newest result waits in r_hold until it is known whether it is last
                S_PUTU: begin
                    if (!r_hv || out_free) begin
                        r_hold  <= res_unstall;
                        r_hv    <= 1'b1;
                        r_state <= S_PUTF;
                    end
                end
                S_PUTF: begin
                    if (!r_hv || out_free) begin
                        r_hold  <= r_fwd;
                        r_hv    <= 1'b1;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_step == LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step  <= r_step + 3'd1;
                        r_idx   <= idx_nxt;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_hv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

>>> design/mrr_chk.sv
`timescale 1ns / 1ps
// mrr_chk: port-level checker for the mesh router, bound to the top level.
// Depends on mrr_pkg.
module mrr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_req_id,
    input logic       o_source_must_stall,
    input logic       o_overflow,
    input logic       o_last
);

    // a held result keeps its kind and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_last))
        else $error("output transaction changed while stalled");

    // an unstall is always followed by its forwarded request
    a_unstall_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == mrr_pkg::KIND_UNSTALL |-> !o_last)
        else $error("unstall marked last");

    a_push_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == mrr_pkg::KIND_PUSH || o_kind == mrr_pkg::KIND_IDLE) |-> o_last)
        else $error("single-result transaction not marked last");

    // a full queue holds more than any limit
    a_ovf_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == mrr_pkg::KIND_PUSH && o_overflow |-> o_source_must_stall)
        else $error("overflow without stall");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != mrr_pkg::KIND_FWD |-> o_out_req_id == 8'd0)
        else $error("request id on non-forward result");

endmodule

bind mesh_router_round_robin_zxy_core mrr_chk u_mrr_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_kind              (o_kind),
    .o_out_req_id        (o_out_req_id),
    .o_source_must_stall (o_source_must_stall),
    .o_overflow          (o_overflow),
    .o_last              (o_last)
);

>>> verif/mrr_checker.sv
`timescale 1ns / 1ps
// mrr_checker: watches the request, result and APB channels of the mesh router,
// predicts the result transactions and compares them in order. Depends on mrr_pkg.
module mrr_checker
    import mrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_source_x,
    input  logic [3:0]  i_source_y,
    input  logic [2:0]  i_source_z,
    input  logic [3:0]  i_dest_x,
    input  logic [3:0]  i_dest_y,
    input  logic [2:0]  i_dest_z,
    input  logic [7:0]  i_req_id,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_kind,
    input  logic [2:0]  o_port,
    input  logic [7:0]  o_out_req_id,
    input  logic [3:0]  o_out_dest_x,
    input  logic [3:0]  o_out_dest_y,
    input  logic [2:0]  o_out_dest_z,
    input  logic        o_source_must_stall,
    input  logic        o_overflow,
    input  logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    t_cfg       cfg;
    logic [3:0] ent_dx [NPORTS][QUEUE_DEPTH];
    logic [3:0] ent_dy [NPORTS][QUEUE_DEPTH];
    logic [2:0] ent_dz [NPORTS][QUEUE_DEPTH];
    logic [7:0] ent_id [NPORTS][QUEUE_DEPTH];
    int         q_head [NPORTS];
    int         q_count[NPORTS];
    bit         out_stalled[NPORTS];
    int         rr_next;
    t_res       due_res[$];
    t_res       step_res[$];

    assign o_pending = due_res.size();

    function automatic logic [2:0] facing_port(logic [3:0] x, logic [3:0] y, logic [2:0] z);
        if (z != cfg.pos_z) return (z < cfg.pos_z) ? P_ZMINUS : P_ZPLUS;
        if (x != cfg.pos_x) return (x < cfg.pos_x) ? P_LEFT : P_RIGHT;
        if (y != cfg.pos_y) return (y < cfg.pos_y) ? P_DOWN : P_UP;
        return P_LOCAL;
    endfunction

    function automatic t_res make_res(logic [1:0] kind, logic [2:0] port);
        t_res r;
        r = '0;
        r.kind = kind;
        r.port = port;
        return r;
    endfunction

    // one accepted transaction: update router state, queue the results it causes
    task automatic predict_step(logic [1:0] op, logic [3:0] sx, logic [3:0] sy,
                                logic [2:0] sz, logic [3:0] dx, logic [3:0] dy,
                                logic [2:0] dz, logic [7:0] id);
        logic [2:0] q;
        logic [2:0] dir;
        bit         taken[NPORTS];
        bit         on_mesh;
        int         idx, slot, nx, ny, nz;
        t_res       r;
        step_res.delete();
        if (op == OP_PUSH) begin
            q = facing_port(sx, sy, sz);
            r = make_res(KIND_PUSH, q);
            if (q_count[q] >= QUEUE_DEPTH) begin
                r.ovf = 1'b1;
            end else begin
                slot = (q_head[q] + q_count[q]) % QUEUE_DEPTH;
                ent_dx[q][slot] = dx;
                ent_dy[q][slot] = dy;
                ent_dz[q][slot] = dz;
                ent_id[q][slot] = id;
                q_count[q]++;
            end
            r.stall = (q_count[q] > cfg.queue_limit);
            step_res = {step_res, r};
        end else if (op == OP_TICK) begin
            foreach (taken[i]) taken[i] = 0;
            idx = rr_next % NPORTS;
            for (int n = 0; n < NPORTS; n++) begin
                if (q_count[idx] != 0) begin
                    slot = q_head[idx];
                    nx = cfg.pos_x;
                    ny = cfg.pos_y;
                    nz = cfg.pos_z;
                    if (ent_dx[idx][slot] == cfg.pos_x && ent_dy[idx][slot] == cfg.pos_y
                            && ent_dz[idx][slot] == cfg.pos_z) begin
                        dir = P_LOCAL;
                    end else if (ent_dz[idx][slot] != cfg.pos_z) begin
                        dir = (ent_dz[idx][slot] < cfg.pos_z) ? P_ZMINUS : P_ZPLUS;
                        nz += (ent_dz[idx][slot] < cfg.pos_z) ? -1 : 1;
                    end else if (ent_dx[idx][slot] != cfg.pos_x) begin
                        dir = (ent_dx[idx][slot] < cfg.pos_x) ? P_LEFT : P_RIGHT;
                        nx += (ent_dx[idx][slot] < cfg.pos_x) ? -1 : 1;
                    end else begin
                        dir = (ent_dy[idx][slot] < cfg.pos_y) ? P_DOWN : P_UP;
                        ny += (ent_dy[idx][slot] < cfg.pos_y) ? -1 : 1;
                    end
                    on_mesh = (dir == P_LOCAL) ||
                              (nx >= 0 && ny >= 0 && nz >= 0 && nx < int'(cfg.mesh_x_count)
                               && ny < int'(cfg.mesh_y_count) && nz < int'(cfg.mesh_z_count));
                    // reservation happens even when the output is stalled
                    if (!taken[dir]) begin
                        taken[dir] = 1;
                        if (!out_stalled[dir]) begin
                            q_head[idx] = (q_head[idx] + 1) % QUEUE_DEPTH;
                            q_count[idx]--;
                            if (q_count[idx] == cfg.queue_limit)
                                step_res = {step_res, make_res(KIND_UNSTALL, 3'(idx))};
                            r = make_res(KIND_FWD, on_mesh ? dir : P_LOCAL);
                            r.id = ent_id[idx][slot];
                            r.dx = ent_dx[idx][slot];
                            r.dy = ent_dy[idx][slot];
                            r.dz = ent_dz[idx][slot];
                            step_res = {step_res, r};
                            rr_next = (idx + 1) % NPORTS;
                        end
                    end
                end
                idx = (idx + 1) % NPORTS;
            end
            if (step_res.size() == 0)
                step_res = {step_res, make_res(KIND_IDLE, P_RIGHT)};
        end else begin
            q = facing_port(sx, sy, sz);
            out_stalled[q] = (op == OP_STALL);
            step_res = {step_res, make_res(KIND_IDLE, q)};
        end
        step_res[step_res.size() - 1].last = 1'b1;
        due_res = {due_res, step_res};
    endtask

    function automatic bit field_ok(string name, int want, int got);
        if (want != got)
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        return want == got;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        bit   ok;
        if (!i_rst_n) begin
            cfg <= '{pos_x: 4'd0, pos_y: 4'd0, pos_z: 3'd0, mesh_x_count: 5'd4,
                     mesh_y_count: 5'd4, mesh_z_count: 4'd1, queue_limit: 3'd4};
            foreach (q_head[i]) begin
                q_head[i] = 0;
                q_count[i] = 0;
                out_stalled[i] = 0;
            end
            rr_next = 0;
            due_res.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_POS_X:  cfg.pos_x        <= pwdata[3:0];
                    REG_POS_Y:  cfg.pos_y        <= pwdata[3:0];
                    REG_POS_Z:  cfg.pos_z        <= pwdata[2:0];
                    REG_MESH_X: cfg.mesh_x_count <= pwdata[4:0];
                    REG_MESH_Y: cfg.mesh_y_count <= pwdata[4:0];
                    REG_MESH_Z: cfg.mesh_z_count <= pwdata[3:0];
                    REG_LIMIT:  cfg.queue_limit  <= pwdata[2:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                predict_step(i_opcode, i_source_x, i_source_y, i_source_z,
                             i_dest_x, i_dest_y, i_dest_z, i_req_id);
            if (o_valid && i_ready) begin
                if (due_res.size() == 0) begin
                    $display("%0t: result transaction with none expected, actual kind %0d",
                             $time, o_kind);
                    o_errors <= o_errors + 1;
                end else begin
                    e = due_res.pop_front();
                    ok = field_ok("kind", e.kind, o_kind);
                    ok &= field_ok("port", e.port, o_port);
                    ok &= field_ok("out_req_id", e.id, o_out_req_id);
                    ok &= field_ok("out_dest_x", e.dx, o_out_dest_x);
                    ok &= field_ok("out_dest_y", e.dy, o_out_dest_y);
                    ok &= field_ok("out_dest_z", e.dz, o_out_dest_z);
                    ok &= field_ok("source_must_stall", e.stall, o_source_must_stall);
                    ok &= field_ok("overflow", e.ovf, o_overflow);
                    ok &= field_ok("last", e.last, o_last);
                    if (!ok) o_errors <= o_errors + 1;
                end
            end
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: drives requests, ticks, stalls and APB writes into the mesh router.
// Depends on mrr_pkg, mesh_router_round_robin_zxy_core and mrr_checker.
module testbench;
    import mrr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [3:0]  i_source_x = '0, i_source_y = '0, i_dest_x = '0, i_dest_y = '0;
    logic [2:0]  i_source_z = '0, i_dest_z = '0;
    logic [7:0]  i_req_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [2:0]  o_port;
    logic [7:0]  o_out_req_id;
    logic [3:0]  o_out_dest_x, o_out_dest_y;
    logic [2:0]  o_out_dest_z;
    logic        o_source_must_stall, o_overflow, o_last;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          long_hold_req = 0;
    bit          no_gaps = 0;
    logic [3:0]  px, py;
    logic [2:0]  pz;

    localparam int WATCHDOG_LIMIT = 5000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mesh_router_round_robin_zxy_core DUT (.*);

    mrr_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // result side: random back-pressure plus an occasional long hold-off
    always @(posedge i_clk) begin
        int hold_left, gap_left;
        if (!i_rst_n) begin
            hold_left = 0;
            gap_left = 0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 300;
            i_ready <= 1'b0;
        end else if (gap_left > 0) begin
            i_ready <= 1'b0;
            gap_left--;
        end else begin
            i_ready <= 1'b1;
            gap_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send(logic [1:0] op, logic [3:0] sx, logic [3:0] sy, logic [2:0] sz,
                        logic [3:0] dx, logic [3:0] dy, logic [2:0] dz, logic [7:0] id);
        int g;
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_source_x <= sx;
        i_source_y <= sy;
        i_source_z <= sz;
        i_dest_x   <= dx;
        i_dest_y   <= dy;
        i_dest_z   <= dz;
        i_req_id   <= id;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [3:0] x, logic [3:0] y, logic [2:0] z, logic [4:0] cx,
                             logic [4:0] cy, logic [3:0] cz, logic [2:0] lim);
        apb_write(REG_POS_X, 32'(x));
        apb_write(REG_POS_Y, 32'(y));
        apb_write(REG_POS_Z, 32'(z));
        apb_write(REG_MESH_X, 32'(cx));
        apb_write(REG_MESH_Y, 32'(cy));
        apb_write(REG_MESH_Z, 32'(cz));
        apb_write(REG_LIMIT, 32'(lim));
        px = x;
        py = y;
        pz = z;
    endtask

    // random traffic: mostly pushes from random sources and ticks, some stall noise
    task automatic random_items(int count);
        int r;
        logic [3:0] sx, sy;
        logic [2:0] sz;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            sx = px;
            sy = py;
            sz = pz;
            case ($urandom_range(0, 3))
                0: sx = 4'($urandom);
                1: sy = 4'($urandom);
                2: sz = 3'($urandom);
                default: begin
                    sx = 4'($urandom);
                    sy = 4'($urandom);
                    sz = 3'($urandom);
                end
            endcase
            if (r < 50)
                send(OP_PUSH, sx, sy, sz, 4'($urandom), 4'($urandom), 3'($urandom),
                     8'($urandom));
            else if (r < 85)
                send(OP_TICK, 4'($urandom), 4'($urandom), 3'($urandom), 4'($urandom),
                     4'($urandom), 3'($urandom), 8'($urandom));
            else if (r < 92)
                send(OP_STALL, sx, sy, sz, 4'($urandom), 4'($urandom), 3'($urandom),
                     8'($urandom));
            else
                send(OP_UNSTALL, sx, sy, sz, 4'($urandom), 4'($urandom), 3'($urandom),
                     8'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: router at (1,1,1) in a 4x4x3 mesh
        configure(4'd1, 4'd1, 3'd1, 5'd4, 5'd4, 4'd3, 3'd4);
        send(OP_TICK, '0, '0, '0, '0, '0, '0, '0);          // idle tick
        send(OP_PUSH, 4'd2, 4'd1, 3'd1, 4'd15, 4'd15, 3'd7, 8'd255);
        send(OP_PUSH, 4'd0, 4'd1, 3'd1, 4'd0, 4'd0, 3'd0, 8'd0);
        send(OP_PUSH, 4'd1, 4'd2, 3'd1, 4'd1, 4'd3, 3'd1, 8'd3);
        send(OP_PUSH, 4'd1, 4'd0, 3'd1, 4'd1, 4'd0, 3'd1, 8'd4);
        send(OP_PUSH, 4'd1, 4'd1, 3'd2, 4'd1, 4'd1, 3'd2, 8'd5);
        send(OP_PUSH, 4'd1, 4'd1, 3'd0, 4'd1, 4'd1, 3'd0, 8'd6);
        send(OP_STALL, 4'd2, 4'd1, 3'd1, '0, '0, '0, '0);   // stall right output
        send(OP_TICK, '0, '0, '0, '0, '0, '0, '0);
        send(OP_UNSTALL, 4'd2, 4'd1, 3'd1, '0, '0, '0, '0);
        // local queue past the limit and into overflow
        for (int n = 0; n < 10; n++)
            send(OP_PUSH, 4'd1, 4'd1, 3'd1, 4'd1, 4'd1, 3'd1, 8'(n));
        for (int n = 0; n < 4; n++)
            send(OP_TICK, 4'd15, 4'd15, 3'd7, 4'd15, 4'd15, 3'd7, 8'd255);
        random_items(50);
        drain();

        // smallest mesh, limit 1; long receiver hold-off while pushing
        configure(4'd0, 4'd0, 3'd0, 5'd1, 5'd1, 4'd1, 3'd1);
        long_hold_req = 1;
        random_items(70);
        drain();

        // largest mesh, no idling, sender pauses for the result side
        no_gaps = 1;
        configure(4'd15, 4'd15, 3'd7, 5'd16, 5'd16, 4'd8, 3'd7);
        random_items(35);
        drain();
        random_items(35);
        no_gaps = 0;
        drain();

        // out-of-range register values, zero counts included
        configure(4'($urandom), 4'($urandom), 3'($urandom), 5'd0, 5'd31, 4'd15, 3'd0);
        random_items(40);
        drain();
        configure(4'($urandom), 4'($urandom), 3'($urandom), 5'($urandom_range(1, 16)),
                  5'($urandom_range(1, 16)), 4'($urandom_range(1, 8)),
                  3'($urandom_range(1, 7)));
        random_items(40);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
